// ===== rtl/sn2lcd_pkg.sv =====
package sn2lcd_pkg;

    localparam int MAG_W   = 17;
    localparam int PLACE_W = 3;

    localparam logic [7:0] DASH_SEG = 8'h02;

    localparam logic signed [31:0] UPPER_LO = -32'sd999;
    localparam logic signed [31:0] UPPER_HI = 32'sd9999;
    localparam logic signed [31:0] LOWER_LO = -32'sd9999;
    localparam logic signed [31:0] LOWER_HI = 32'sd99999;

    localparam logic [PLACE_W-1:0] UPPER_PLACES = 3'd4;
    localparam logic [PLACE_W-1:0] LOWER_PLACES = 3'd5;

    // floor(x/10) = (x * RECIP_10) >> RECIP_SHIFT for x below 2^22
    localparam logic [19:0] RECIP_10    = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    typedef struct packed {
        logic load;
        logic emit_digit;
        logic emit_sign;
        logic emit_dash;
    } t_cmd;

    typedef struct packed {
        logic out_range;
        logic neg;
        logic digits_done;
        logic dash_done;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [3:0] index;
        logic [7:0] seg;
    } t_write;

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hF5;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hB6;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h63;
            4'd5:    s = 8'hD3;
            4'd6:    s = 8'hD7;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'hF7;
            4'd9:    s = 8'hF3;
            default: s = 8'hF5;
        endcase
        return s;
    endfunction

    function automatic t_write map_write(input logic [PLACE_W-1:0] place, input logic upper,
                                         input logic [7:0] seg);
        t_write w;
        logic [3:0] idx;
        if (upper) begin
            idx = (place == 3'd4) ? 4'd5 : {1'b0, place};
            w.seg = seg;
        end else begin
            idx = 4'd12 - {1'b0, place};
            w.seg = {seg[3:0], seg[7:4]};
        end
        w.index = (idx > 4'd11) ? 4'd4 : idx;
        return w;
    endfunction

endpackage

// ===== rtl/sn2lcd_dp.sv =====
module sn2lcd_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_value,
    input  logic                  i_upper_line,
    input  sn2lcd_pkg::t_cmd      i_cmd,
    output sn2lcd_pkg::t_status   o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [3:0]            o_memory_index,
    output logic [7:0]            o_segment_byte,
    output logic                  o_last
);

    logic [sn2lcd_pkg::MAG_W-1:0]   r_mag;
    logic [sn2lcd_pkg::PLACE_W-1:0] r_place;
    logic                           r_upper;
    logic                           r_neg;
    logic                           r_out_valid;
    logic [3:0]                     r_index;
    logic [7:0]                     r_seg;
    logic                           r_last;

    logic signed [31:0]             in_lo;
    logic signed [31:0]             in_hi;
    logic                           in_range_bad;
    logic [31:0]                    in_abs;
    logic [sn2lcd_pkg::PLACE_W-1:0] in_places;
    logic [sn2lcd_pkg::PLACE_W-1:0] places;

    logic [36:0]                    prod;
    logic [sn2lcd_pkg::MAG_W-1:0]   quot;
    logic [sn2lcd_pkg::MAG_W-1:0]   rem_full;
    logic [7:0]                     emit_seg;
    sn2lcd_pkg::t_write             wr;
    logic                           emit;
    logic                           emit_last;

    assign in_lo        = i_upper_line ? sn2lcd_pkg::UPPER_LO : sn2lcd_pkg::LOWER_LO;
    assign in_hi        = i_upper_line ? sn2lcd_pkg::UPPER_HI : sn2lcd_pkg::LOWER_HI;
    assign in_range_bad = ($signed(i_value) < in_lo) || ($signed(i_value) > in_hi);
    assign in_abs       = i_value[31] ? (32'd0 - i_value) : i_value;
    assign in_places    = i_upper_line ? sn2lcd_pkg::UPPER_PLACES : sn2lcd_pkg::LOWER_PLACES;
    assign places       = r_upper ? sn2lcd_pkg::UPPER_PLACES : sn2lcd_pkg::LOWER_PLACES;

    assign prod     = {20'd0, r_mag} * {17'd0, sn2lcd_pkg::RECIP_10};
    assign quot     = {3'd0, prod[sn2lcd_pkg::RECIP_SHIFT +: 14]};
    assign rem_full = r_mag - {quot[13:0], 3'b000} - {quot[15:0], 1'b0};

    always_comb begin
        emit_seg  = sn2lcd_pkg::DASH_SEG;
        emit_last = 1'b0;
        if (i_cmd.emit_digit) begin
            emit_seg  = sn2lcd_pkg::digit_seg(rem_full[3:0]);
            emit_last = o_status.digits_done && !r_neg;
        end else if (i_cmd.emit_sign) begin
            emit_last = 1'b1;
        end else if (i_cmd.emit_dash) begin
            emit_last = o_status.dash_done;
        end
    end

    assign wr   = sn2lcd_pkg::map_write(r_place, r_upper, emit_seg);
    assign emit = i_cmd.emit_digit || i_cmd.emit_sign || i_cmd.emit_dash;

    assign o_status.out_range   = in_range_bad;
    assign o_status.neg         = r_neg;
    assign o_status.digits_done = (quot == '0) || (r_place == 3'd1);
    assign o_status.dash_done   = (r_place == places);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_upper <= i_upper_line;
            r_neg   <= i_value[31];
            r_mag   <= in_abs[sn2lcd_pkg::MAG_W-1:0];
            r_place <= in_range_bad ? 3'd1 : in_places;
        end else if (i_cmd.emit_digit) begin
            r_mag   <= quot;
            r_place <= r_place - 3'd1;
        end else if (i_cmd.emit_dash) begin
            r_place <= r_place + 3'd1;
        end
        if (emit) begin
            r_index <= wr.index;
            r_seg   <= wr.seg;
            r_last  <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_memory_index = r_index;
    assign o_segment_byte = r_seg;
    assign o_last         = r_last;

endmodule

// ===== rtl/sn2lcd_ctrl.sv =====
module sn2lcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sn2lcd_pkg::t_status i_status,
    output sn2lcd_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIGIT = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DASH  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.out_range ? S_DASH : S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.digits_done) begin
                        n_state = i_status.neg ? S_SIGN : S_IDLE;
                    end
                end
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DASH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_dash = 1'b1;
                    if (i_status.dash_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/signed_number_to_lcd_segments.sv =====
// Converts a signed 32-bit number into the run of LCD segment-memory writes
// for one display line: 4 places on the upper line (-999..9999), 5 on the
// lower line (-9999..99999). Each request yields 1 to 5 writes (digits from
// the right, then a minus sign), or a full row of dashes when out of range;
// o_last marks the final write. A request is accepted in the idle state, and
// the divide-by-ten step then yields one digit per cycle while the output is
// not stalled; a new request is taken only once the last write is issued.
module signed_number_to_lcd_segments (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    input  logic        i_upper_line,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_memory_index,
    output logic [7:0]  o_segment_byte,
    output logic        o_last
);

    sn2lcd_pkg::t_cmd    cmd;
    sn2lcd_pkg::t_status status;

    sn2lcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sn2lcd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_upper_line   (i_upper_line),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_memory_index (o_memory_index),
        .o_segment_byte (o_segment_byte),
        .o_last         (o_last)
    );

endmodule

// ===== tb/lcd_write_checker.sv =====
module lcd_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_value,
    input  logic        i_upper_line,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_memory_index,
    input  logic [7:0]  i_segment_byte,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0] index;
        logic [7:0] seg;
        logic       last;
    } t_lcd_write;

    t_lcd_write pending_writes[$];

    function automatic logic [7:0] digit_pattern(input int d);
        logic [7:0] p;
        case (d)
            0:       p = 8'hF5;
            1:       p = 8'h60;
            2:       p = 8'hB6;
            3:       p = 8'hF2;
            4:       p = 8'h63;
            5:       p = 8'hD3;
            6:       p = 8'hD7;
            7:       p = 8'h70;
            8:       p = 8'hF7;
            default: p = 8'hF3;
        endcase
        return p;
    endfunction

    function automatic t_lcd_write placed_write(input int place, input logic upper,
                                                input logic [7:0] pattern);
        t_lcd_write w;
        int idx;
        idx = place;
        w.seg = pattern;
        if (!upper) begin
            idx = 12 - place;
            w.seg = {pattern[3:0], pattern[7:4]};
        end else if (idx == 4) begin
            idx = 5;
        end
        if (idx > 11) begin
            idx = 4;
        end
        w.index = idx[3:0];
        w.last = 1'b0;
        return w;
    endfunction

    // queue the writes one request produces: digits right to left, then sign, or a row of dashes when out of range
    task automatic predict_display_writes(input logic [31:0] raw, input logic upper);
        t_lcd_write run [5];
        t_lcd_write w;
        int count;
        int places;
        int place;
        longint v;
        longint lo;
        longint hi;
        longint mag;
        v = $signed(raw);
        places = upper ? 4 : 5;
        lo = upper ? -999 : -9999;
        hi = upper ? 9999 : 99999;
        count = 0;
        if (v < lo || v > hi) begin
            for (int p = 1; p <= places; p++) begin
                run[count] = placed_write(p, upper, sn2lcd_pkg::DASH_SEG);
                count++;
            end
        end else begin
            mag = (v < 0) ? -v : v;
            place = places;
            do begin
                run[count] = placed_write(place, upper, digit_pattern(int'(mag % 10)));
                count++;
                mag = mag / 10;
                place--;
            end while (mag != 0 && place >= 1);
            if (v < 0) begin
                run[count] = placed_write(place, upper, sn2lcd_pkg::DASH_SEG);
                count++;
            end
        end
        for (int k = 0; k < count; k++) begin
            w = run[k];
            w.last = (k == count - 1);
            pending_writes.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_lcd_write want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            pending_writes.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_writes.size() == 0) begin
                    $error("unexpected write: memory_index %0d segment_byte %02h last %0d",
                           i_memory_index, i_segment_byte, i_last);
                    errs++;
                end else begin
                    want = pending_writes.pop_front();
                    if (i_memory_index !== want.index) begin
                        $error("memory_index: expected %0d, got %0d",
                               want.index, i_memory_index);
                        errs++;
                    end
                    if (i_segment_byte !== want.seg) begin
                        $error("segment_byte: expected %02h, got %02h",
                               want.seg, i_segment_byte);
                        errs++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_display_writes(i_value, i_upper_line);
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= pending_writes.size();
    end

endmodule

// ===== tb/signed_number_to_lcd_segments_tb.sv =====
module signed_number_to_lcd_segments_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_upper_line = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_memory_index;
    logic [7:0]  o_segment_byte;
    logic        o_last;

    int   fail_count;
    int   pending_count;
    logic steady = 1'b0;
    logic hold_start = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_cycles = 0;

    signed_number_to_lcd_segments dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_upper_line   (i_upper_line),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_memory_index (o_memory_index),
        .o_segment_byte (o_segment_byte),
        .o_last         (o_last)
    );

    lcd_write_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_upper_line   (i_upper_line),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_memory_index (o_memory_index),
        .i_segment_byte (o_segment_byte),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always #1 i_clk = ~i_clk;

    // receiver: random stalls, one long hold-off, quiet stretch
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= 80;
            i_out_stall <= 1'b1;
        end else if (steady) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 33);
        end
    end

    task automatic offer(input logic [31:0] v, input logic upper);
        if (!steady && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= v;
        i_upper_line <= upper;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_value(input logic upper);
        int kind;
        int digits;
        longint lim;
        longint lo;
        longint hi;
        longint v;
        lo = upper ? -999 : -9999;
        hi = upper ? 9999 : 99999;
        kind = $urandom_range(99);
        if (kind < 70) begin
            digits = $urandom_range(upper ? 4 : 5, 1);
            lim = 1;
            repeat (digits) lim = lim * 10;
            v = longint'($urandom_range(int'(lim - 1)));
            if ($urandom_range(1) && v <= -lo) begin
                v = -v;
            end
        end else if (kind < 85) begin
            v = ($urandom_range(1) ? lo : hi) + longint'($urandom_range(4)) - 2;
        end else begin
            v = longint'($urandom);
        end
        return v[31:0];
    endfunction

    initial begin
        logic upper;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int u = 0; u < 2; u++) begin
            offer(32'd0, u[0]);
            offer(32'h7FFF_FFFF, u[0]);
            offer(32'h8000_0000, u[0]);
            offer(-32'sd1, u[0]);
        end
        offer(32'd9999, 1'b1);
        offer(32'd10000, 1'b1);
        offer(-32'sd999, 1'b1);
        offer(-32'sd1000, 1'b1);
        offer(32'd1234, 1'b1);
        offer(-32'sd56, 1'b1);
        offer(32'd99999, 1'b0);
        offer(32'd100000, 1'b0);
        offer(-32'sd9999, 1'b0);
        offer(-32'sd10000, 1'b0);
        offer(32'd56789, 1'b0);
        offer(-32'sd7, 1'b0);
        offer(32'd90, 1'b0);

        for (int n = 0; n < 260; n++) begin
            if (n == 40) begin
                hold_start <= 1'b1;
            end
            if (n == 120) begin
                steady <= 1'b1;
            end
            if (n == 170) begin
                steady <= 1'b0;
            end
            upper = 1'($urandom_range(1));
            offer(random_value(upper), upper);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
